FILE: hdl/cprl_pkg.sv
// Shared constants, codes and types of the ray-to-line closest point block.
package cprl_pkg;

  localparam int CW    = 16;          // coordinate width
  localparam int QBITS = CW + 1;      // quotient bits kept before saturation is certain
  localparam int DW    = 65;          // doubled divisor width
  localparam int NW    = 86;          // doubled, rounded numerator width
  localparam int DIV_LAT = QBITS + 1; // register stages in the divider

  localparam logic [1:0] CASE_GENERAL  = 2'd0;
  localparam logic [1:0] CASE_PARALLEL = 2'd1;
  localparam logic [1:0] CASE_DEGEN    = 2'd2;

  localparam logic REG_PARALLEL_LIMIT   = 1'b0;
  localparam logic REG_DEGENERATE_LIMIT = 1'b1;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

endpackage

FILE: hdl/cprl_rdiv.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module cprl_rdiv import cprl_pkg::*; (
  input  logic             clk,
  input  div_req_t         req,
  output logic [QBITS-1:0] quo,
  output logic             big
);

  logic [NW-1:0]    rem_r [0:QBITS-1];
  logic [DW-1:0]    den_r [0:QBITS-1];
  logic [QBITS-1:0] q_r   [0:QBITS];
  logic             big_r [0:QBITS];

  logic [NW-1:0]    rem_nxt [0:QBITS-1];
  logic [QBITS-1:0] q_nxt   [0:QBITS];

  always_comb begin
    logic [NW-1:0] sh;
    logic          ge;
    for (int k = 0; k < QBITS; k++) rem_nxt[k] = '0;
    q_nxt[0] = '0;
    for (int k = 1; k <= QBITS; k++) begin
      sh = NW'(den_r[k-1]) << (QBITS - k);
      ge = rem_r[k-1] >= sh;
      q_nxt[k] = {q_r[k-1][QBITS-2:0], ge};
      if (k < QBITS) begin
        rem_nxt[k] = ge ? rem_r[k-1] - sh : rem_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= req.num;
    den_r[0] <= req.den;
    q_r[0]   <= '0;
    big_r[0] <= req.num >= (NW'(req.den) << QBITS);
    for (int k = 1; k <= QBITS; k++) begin
      q_r[k]   <= q_nxt[k];
      big_r[k] <= big_r[k-1];
      if (k < QBITS) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo = q_r[QBITS];
  assign big = big_r[QBITS];

endmodule

FILE: hdl/closest_point_ray_to_line.sv
// Top level: closest point on a line to a ray, fully pipelined.
//
// Usage: drive a query on the in_* ports with start high; a query is taken
// at every clock edge with start high, since busy stays low. The point on
// the line nearest the ray comes back on out_* with out_valid high for one
// cycle, in query order. Throughput is one query per cycle; nine
// arithmetic stages (difference, products, cross sums, squares, sums, case
// select, partial products, numerator, rounding setup) feed an 18-stage
// divider (an input stage that flags overflow, then one quotient bit per
// stage), then a saturating add stage.
// case_taken tells general solve, parallel projection or degenerate line;
// saturated flags a clamped coordinate.
// The two limit registers are written through cfg_we/cfg_index/cfg_data; the user
// writes them only while no query is in flight (the block does not enforce this); reset loads 43 and 1.
// Reset (rst_n low, synchronous) empties the pipeline; queries in flight
// are dropped. The receiver cannot stall: each result is shown once.
module closest_point_ray_to_line import cprl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_ray_origin_x,
  input  logic signed [CW-1:0] in_ray_origin_y,
  input  logic signed [CW-1:0] in_ray_origin_z,
  input  logic signed [CW-1:0] in_ray_dir_x,
  input  logic signed [CW-1:0] in_ray_dir_y,
  input  logic signed [CW-1:0] in_ray_dir_z,
  input  logic signed [CW-1:0] in_line_point_x,
  input  logic signed [CW-1:0] in_line_point_y,
  input  logic signed [CW-1:0] in_line_point_z,
  input  logic signed [CW-1:0] in_line_dir_x,
  input  logic signed [CW-1:0] in_line_dir_y,
  input  logic signed [CW-1:0] in_line_dir_z,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_closest_x,
  output logic signed [CW-1:0] out_closest_y,
  output logic signed [CW-1:0] out_closest_z,
  output logic [1:0]           out_case_taken,
  output logic                 out_saturated
);

  localparam int PRE = 9;
  localparam int LAT = PRE + DIV_LAT + 1;
  localparam int NX [3] = '{1, 2, 0};
  localparam int NY [3] = '{2, 0, 1};
  localparam logic signed [CW+2:0] CMAX = (CW+3)'((1 << (CW-1)) - 1);
  localparam logic signed [CW+2:0] CMIN = -(CW+3)'(1 << (CW-1));

  logic [15:0] plim_r, dlim_r;
  logic [LAT-1:0] vld_r;

  // stage registers
  logic signed [CW-1:0] p_r [PRE][3];
  logic signed [CW-1:0] u_r [PRE-1][3];
  logic signed [CW-1:0] va_r [3];
  logic signed [CW:0]   wa_r [3];
  logic signed [31:0] muv1_r [3], muv2_r [3], uu_r [3];
  logic signed [32:0] mvw1_r [3], mvw2_r [3], uw_r [3];
  logic signed [32:0] uv_r [3];
  logic signed [33:0] vw_r [3];
  logic [31:0]        a_r [3];
  logic signed [34:0] d_r [3];
  logic [63:0]        sq_r [3];
  logic signed [66:0] pr_r [3];
  logic [63:0]        den_r;
  logic signed [66:0] num_r;
  logic [1:0]         mode_r [PRE-5];
  logic signed [66:0] m_r;
  logic [63:0]        dv_r [3];
  logic signed [49:0] pl_r [3], ph_r [3];
  logic signed [83:0] n_r [3];
  div_req_t           req_r [3];
  logic               neg_r [3];

  // sideband alongside the divider
  logic signed [CW-1:0] ps_r [DIV_LAT][3];
  logic                 ns_r [DIV_LAT][3];
  logic [1:0]           ms_r [DIV_LAT];

  logic [QBITS-1:0] quo [3];
  logic             big [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plim_r <= 16'd43;
      dlim_r <= 16'd1;
      vld_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PARALLEL_LIMIT:   plim_r <= cfg_data;
          REG_DEGENERATE_LIMIT: dlim_r <= cfg_data;
          default: ;
        endcase
      end
      vld_r <= {vld_r[LAT-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    // A: register the query, form w = origin - point
    p_r[0][0] <= in_line_point_x;  p_r[0][1] <= in_line_point_y;
    p_r[0][2] <= in_line_point_z;
    u_r[0][0] <= in_line_dir_x;    u_r[0][1] <= in_line_dir_y;
    u_r[0][2] <= in_line_dir_z;
    va_r[0] <= in_ray_dir_x;  va_r[1] <= in_ray_dir_y;  va_r[2] <= in_ray_dir_z;
    wa_r[0] <= (CW+1)'(in_ray_origin_x) - (CW+1)'(in_line_point_x);
    wa_r[1] <= (CW+1)'(in_ray_origin_y) - (CW+1)'(in_line_point_y);
    wa_r[2] <= (CW+1)'(in_ray_origin_z) - (CW+1)'(in_line_point_z);
    for (int s = 1; s < PRE; s++) p_r[s] <= p_r[s-1];
    for (int s = 1; s < PRE-1; s++) u_r[s] <= u_r[s-1];
    for (int i = 0; i < 3; i++) begin
      // B: products
      muv1_r[i] <= u_r[0][NX[i]] * va_r[NY[i]];
      muv2_r[i] <= u_r[0][NY[i]] * va_r[NX[i]];
      mvw1_r[i] <= va_r[NX[i]] * wa_r[NY[i]];
      mvw2_r[i] <= va_r[NY[i]] * wa_r[NX[i]];
      uu_r[i]   <= u_r[0][i] * u_r[0][i];
      uw_r[i]   <= u_r[0][i] * wa_r[i];
      // C: cross products and dot sums
      uv_r[i] <= 33'(muv1_r[i]) - 33'(muv2_r[i]);
      vw_r[i] <= 34'(mvw1_r[i]) - 34'(mvw2_r[i]);
      // D: squares and numerator terms
      sq_r[i] <= 64'(uv_r[i] * uv_r[i]);
      pr_r[i] <= 67'(uv_r[i]) * 67'(vw_r[i]);
    end
    a_r[0] <= 32'(uu_r[0]) + 32'(uu_r[1]) + 32'(uu_r[2]);
    d_r[0] <= 35'(uw_r[0]) + 35'(uw_r[1]) + 35'(uw_r[2]);
    a_r[1] <= a_r[0];  d_r[1] <= d_r[0];
    a_r[2] <= a_r[1];  d_r[2] <= d_r[1];
    // E: denominator and numerator sums
    den_r <= sq_r[0] + sq_r[1] + sq_r[2];
    num_r <= pr_r[0] + pr_r[1] + pr_r[2];
    // F: pick the case and the divide operands
    if (den_r == 64'd0 || den_r < 64'(plim_r)) begin
      if (a_r[2] == 32'd0 || a_r[2] < 32'(dlim_r)) mode_r[0] <= CASE_DEGEN;
      else mode_r[0] <= CASE_PARALLEL;
      m_r      <= 67'(d_r[2]);
      dv_r[0]  <= 64'(a_r[2]);
    end else begin
      mode_r[0] <= CASE_GENERAL;
      m_r       <= num_r;
      dv_r[0]   <= den_r;
    end
    for (int s = 1; s < PRE-5; s++) mode_r[s] <= mode_r[s-1];
    dv_r[1] <= dv_r[0];
    dv_r[2] <= dv_r[1];
    for (int i = 0; i < 3; i++) begin
      // G: split multiply by the line direction
      pl_r[i] <= $signed({1'b0, m_r[32:0]}) * u_r[PRE-4][i];
      ph_r[i] <= $signed(m_r[66:33]) * u_r[PRE-4][i];
      // H: assemble the numerator
      n_r[i] <= (84'(ph_r[i]) <<< 33) + 84'(pl_r[i]);
      // I: round-to-nearest setup, (2|n| + dv) / 2dv
      neg_r[i]     <= n_r[i][83];
      req_r[i].num <= {1'b0, (n_r[i][83] ? -n_r[i] : n_r[i]), 1'b0} +
                      NW'(dv_r[2]);
      req_r[i].den <= {dv_r[2], 1'b0};
    end
    // sideband through the divider
    ps_r[0] <= p_r[PRE-1];
    ns_r[0] <= neg_r;
    ms_r[0] <= mode_r[PRE-6];
    for (int s = 1; s < DIV_LAT; s++) begin
      ps_r[s] <= ps_r[s-1];
      ns_r[s] <= ns_r[s-1];
      ms_r[s] <= ms_r[s-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    cprl_rdiv u_div (
      .clk (clk),
      .req (req_r[i]),
      .quo (quo[i]),
      .big (big[i])
    );
  end

  // final add and clamp
  logic signed [CW-1:0] res [3];
  logic                 clip [3];

  always_comb begin
    logic signed [CW+2:0] qs;
    logic signed [CW+2:0] sum;
    for (int i = 0; i < 3; i++) begin
      qs  = ns_r[DIV_LAT-1][i] ? -(CW+3)'(quo[i]) : (CW+3)'(quo[i]);
      sum = (CW+3)'(ps_r[DIV_LAT-1][i]) + qs;
      res[i]  = CW'(sum);
      clip[i] = 1'b0;
      if (ms_r[DIV_LAT-1] == CASE_DEGEN) begin
        res[i] = ps_r[DIV_LAT-1][i];
      end else if (big[i]) begin
        res[i]  = ns_r[DIV_LAT-1][i] ? CW'(CMIN) : CW'(CMAX);
        clip[i] = 1'b1;
      end else if (sum < CMIN) begin
        res[i]  = CW'(CMIN);
        clip[i] = 1'b1;
      end else if (sum > CMAX) begin
        res[i]  = CW'(CMAX);
        clip[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_closest_x  <= res[0];
    out_closest_y  <= res[1];
    out_closest_z  <= res[2];
    out_case_taken <= ms_r[DIV_LAT-1];
    out_saturated  <= clip[0] | clip[1] | clip[2];
  end

  assign out_valid = vld_r[LAT-1];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##28 out_valid)
    else $error("result did not appear at the fixed latency");
  a_degen_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_case_taken == CASE_DEGEN) |-> !out_saturated)
    else $error("degenerate result flagged as saturated");
  a_case_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_case_taken != 2'd3))
    else $error("unused case code on output");
  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_closest_x == CW'(CMAX) || out_closest_x == CW'(CMIN) ||
       out_closest_y == CW'(CMAX) || out_closest_y == CW'(CMIN) ||
       out_closest_z == CW'(CMAX) || out_closest_z == CW'(CMIN)))
    else $error("saturated flag without a clamped coordinate");

endmodule
